/* rtl/amx_pkg.sv */
package amx_pkg;

	localparam int OP_BITS   = 7;
	localparam int ADDR_BITS = 7;
	localparam int IO_BITS   = 32;

	localparam logic [OP_BITS-1:0] OP_READ  = 7'd10;
	localparam logic [OP_BITS-1:0] OP_WRITE = 7'd11;
	localparam logic [OP_BITS-1:0] OP_LOAD  = 7'd20;
	localparam logic [OP_BITS-1:0] OP_STORE = 7'd21;
	localparam logic [OP_BITS-1:0] OP_ADD   = 7'd30;
	localparam logic [OP_BITS-1:0] OP_SUB   = 7'd31;
	localparam logic [OP_BITS-1:0] OP_MUL   = 7'd32;
	localparam logic [OP_BITS-1:0] OP_DIV   = 7'd33;
	localparam logic [OP_BITS-1:0] OP_HALT  = 7'd43;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_OP   = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_HALTED   = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic exec;
		logic step;
		logic finish;
		logic out_load;
	} amx_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic long_op;
		logic last_step;
		logic out_free;
	} amx_sts_t;

endpackage

/* rtl/amx_if.sv */
interface amx_in_if import amx_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic        [OP_BITS-1:0]   op;
	logic        [ADDR_BITS-1:0] address;
	logic signed [IO_BITS-1:0]   read_value;

	modport source (output valid, output op, output address, output read_value, input ready);
	modport sink (input valid, input op, input address, input read_value, output ready);
endinterface

interface amx_out_if import amx_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [IO_BITS-1:0] accumulator;
	logic signed [IO_BITS-1:0] write_data;
	logic                      write_valid;
	logic        [1:0]         status;

	modport source (output valid, output accumulator, output write_data, output write_valid,
		output status, input ready);
	modport sink (input valid, input accumulator, input write_data, input write_valid,
		input status, output ready);
endinterface

/* rtl/amx_ram.sv */
module amx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 100,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/amx_ctrl.sv */
module amx_ctrl import amx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  amx_sts_t sts,
	output amx_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EXEC = 6'b000100,
		S_ITER = 6'b001000,
		S_FIN  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.long_op ? S_ITER : S_DONE;
			end
			S_ITER: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/amx_dp.sv */
module amx_dp import amx_pkg::*; #(
	parameter int MEM_WORDS = 100,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  amx_cmd_t                    cmd,
	output amx_sts_t                    sts,
	input  logic        [OP_BITS-1:0]   op,
	input  logic        [ADDR_BITS-1:0] address,
	input  logic signed [IO_BITS-1:0]   read_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [IO_BITS-1:0]   accumulator,
	output logic signed [IO_BITS-1:0]   write_data,
	output logic                        write_valid,
	output logic        [1:0]           status
);

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int CW = $clog2(WORD_BITS + 1);
	localparam logic [ADDR_BITS-1:0] ADDR_LIMIT = ADDR_BITS'(MEM_WORDS);

	typedef logic [WORD_BITS-1:0] word_t;

	// Request registers.
	logic [OP_BITS-1:0] op_q;
	logic [AW-1:0]      idx_q;
	logic               in_range_q;
	logic               hit_q;
	word_t              rv_q;

	// Architectural state; vld_q marks words written since reset.
	word_t              acc_q;
	logic               halted_q;
	logic [MEM_WORDS-1:0] vld_q;

	// Shared shift-add / restoring-divide registers.
	word_t   prod_q;
	word_t   mcand_q;
	word_t   mplier_q;
	logic    neg_q;
	logic [CW-1:0] cnt_q;

	// Result collected during execution.
	word_t   wdata_q;
	logic    wvalid_q;
	status_t status_q;

	// Output register.
	logic                      out_valid_q;
	logic signed [IO_BITS-1:0] acc_out_q;
	logic signed [IO_BITS-1:0] wdata_out_q;
	logic                      wvalid_out_q;
	status_t                   status_out_q;

	logic                 in_range;
	logic [AW-1:0]        idx;
	word_t                ram_rdata;
	word_t                m;
	logic                 ram_we;
	word_t                ram_wdata;
	word_t                acc_mag;
	word_t                m_mag;
	logic [WORD_BITS:0]   trial;

	assign in_range = address < ADDR_LIMIT;
	assign idx      = address[AW-1:0];

	assign m       = hit_q ? ram_rdata : '0;
	assign acc_mag = acc_q[WORD_BITS-1] ? word_t'(-acc_q) : acc_q;
	assign m_mag   = m[WORD_BITS-1] ? word_t'(-m) : m;
	assign trial   = {prod_q, mcand_q[WORD_BITS-1]} - {1'b0, mplier_q};

	assign ram_we    = cmd.exec && !halted_q && in_range_q &&
		(op_q == OP_READ || op_q == OP_STORE);
	assign ram_wdata = (op_q == OP_READ) ? rv_q : acc_q;

	amx_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	assign sts.long_op   = !halted_q && (op_q == OP_MUL || (op_q == OP_DIV && m != '0));
	assign sts.last_step = cnt_q == CW'(1);
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= op;
			idx_q      <= idx;
			in_range_q <= in_range;
			hit_q      <= in_range && vld_q[idx];
			rv_q       <= WORD_BITS'(read_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			halted_q <= 1'b0;
			vld_q    <= '0;
		end else begin
			if (ram_we) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (cmd.exec && !halted_q) begin
				unique case (op_q)
					OP_LOAD: acc_q <= m;
					OP_ADD:  acc_q <= acc_q + m;
					OP_SUB:  acc_q <= acc_q - m;
					OP_HALT: halted_q <= 1'b1;
					default: begin
					end
				endcase
			end
			if (cmd.finish) begin
				if (op_q == OP_DIV) begin
					acc_q <= neg_q ? word_t'(-mcand_q) : mcand_q;
				end else begin
					acc_q <= prod_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			wdata_q  <= '0;
			wvalid_q <= 1'b0;
			status_q <= ST_OK;
			cnt_q    <= CW'(WORD_BITS);
			prod_q   <= '0;
			neg_q    <= acc_q[WORD_BITS-1] ^ m[WORD_BITS-1];
			// Multiply walks the multiplier; divide shifts the dividend out of mcand_q.
			mcand_q  <= (op_q == OP_DIV) ? acc_mag : acc_q;
			mplier_q <= (op_q == OP_DIV) ? m_mag : m;
			if (halted_q) begin
				status_q <= ST_HALTED;
			end else begin
				unique case (op_q)
					OP_READ, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_HALT: begin
					end
					OP_WRITE: begin
						wdata_q  <= m;
						wvalid_q <= 1'b1;
					end
					OP_DIV: begin
						if (m == '0) begin
							status_q <= ST_DIV_ZERO;
						end
					end
					default: status_q <= ST_BAD_OP;
				endcase
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CW'(1);
			if (op_q == OP_DIV) begin
				if (!trial[WORD_BITS]) begin
					prod_q  <= trial[WORD_BITS-1:0];
					mcand_q <= {mcand_q[WORD_BITS-2:0], 1'b1};
				end else begin
					prod_q  <= {prod_q[WORD_BITS-2:0], mcand_q[WORD_BITS-1]};
					mcand_q <= {mcand_q[WORD_BITS-2:0], 1'b0};
				end
			end else begin
				prod_q   <= prod_q + (mplier_q[0] ? mcand_q : '0);
				mcand_q  <= {mcand_q[WORD_BITS-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[WORD_BITS-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			acc_out_q    <= IO_BITS'($signed(acc_q));
			wdata_out_q  <= IO_BITS'($signed(wdata_q));
			wvalid_out_q <= wvalid_q;
			status_out_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign accumulator = acc_out_q;
	assign write_data  = wdata_out_q;
	assign write_valid = wvalid_out_q;
	assign status      = status_out_q;

endmodule

/* rtl/accumulator_machine_execute_top.sv */
// Executes one accumulator-machine instruction per request against a MEM_WORDS-deep
// data memory and one accumulator, and returns one result per request carrying the
// accumulator, any write output and a status code. Requests are taken one at a time:
// load, store, read, write, add, subtract, halt, rejected, divide-by-zero and halted
// requests pass through the read, execute and done states; multiply and nonzero divide
// run WORD_BITS steps of the shared shift-add / restoring-divide unit, then finish.
// The output register lets the next request be accepted while a result still waits.
// Memory words read as zero until written; no clearing pass is needed after reset.
module accumulator_machine_execute_top import amx_pkg::*; #(
	parameter int MEM_WORDS = 100,
	parameter int WORD_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	amx_in_if.sink   in_ch,
	amx_out_if.source out_ch
);

	amx_cmd_t cmd;
	amx_sts_t sts;

	amx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	amx_dp #(
		.MEM_WORDS (MEM_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (in_ch.op),
		.address     (in_ch.address),
		.read_value  (in_ch.read_value),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.accumulator (out_ch.accumulator),
		.write_data  (out_ch.write_data),
		.write_valid (out_ch.write_valid),
		.status      (out_ch.status)
	);

endmodule

/* rtl/amx_checker.sv */
module amx_checker import amx_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [IO_BITS-1:0] write_data,
	input logic                      write_valid,
	input logic        [1:0]         status
);

	logic halt_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_seen_q <= 1'b0;
		end else if (out_valid && out_ready && status == ST_HALTED) begin
			halt_seen_q <= 1'b1;
		end
	end

	// Requests are executed one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another was in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(write_data))
		else $error("stalled result changed");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!write_valid || status != ST_OK) |-> !write_valid && write_data == '0)
		else $error("write data shown without an executed write");

	// Once halted, the machine stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halt_seen_q |-> status == ST_HALTED)
		else $error("result after halt not flagged as halted");

endmodule

bind accumulator_machine_execute_top amx_checker u_amx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.write_data  (out_ch.write_data),
	.write_valid (out_ch.write_valid),
	.status      (out_ch.status)
);

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import amx_pkg::*;

	localparam int MEM_WORDS    = 100;
	localparam int WORD_BITS    = 32;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_ITEMS  = 640;

	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [31:0] accumulator;
		logic [31:0] write_data;
		logic        write_valid;
		status_t     status;
	} instr_result_t;

	// Mirrors the machine state and queues the result each accepted instruction must give.
	class instr_scoreboard;
		logic [31:0]   data_mem [MEM_WORDS];
		logic [31:0]   acc;
		bit            halted;
		instr_result_t pending_results [$];
		int            errors;

		function new();
			foreach (data_mem[i])
				data_mem[i] = '0;
			acc = '0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function instr_result_t execute_instr(logic [6:0] op, logic [6:0] addr,
				logic [31:0] value);
			instr_result_t r;
			logic [31:0]   word;
			logic [31:0]   num;
			logic [31:0]   den;
			logic [31:0]   quo;
			logic          neg;
			r.write_data = '0;
			r.write_valid = 1'b0;
			r.status = ST_OK;
			// Addresses past the end of memory read as zero and drop writes.
			word = (addr < MEM_WORDS) ? data_mem[addr] : '0;
			if (halted) begin
				r.status = ST_HALTED;
			end else begin
				case (op)
					OP_READ: begin
						if (addr < MEM_WORDS)
							data_mem[addr] = value;
					end
					OP_WRITE: begin
						r.write_data = word;
						r.write_valid = 1'b1;
					end
					OP_LOAD: acc = word;
					OP_STORE: begin
						if (addr < MEM_WORDS)
							data_mem[addr] = acc;
					end
					OP_ADD: acc = acc + word;
					OP_SUB: acc = acc - word;
					OP_MUL: acc = acc * word;
					OP_DIV: begin
						if (word == '0) begin
							r.status = ST_DIV_ZERO;
						end else begin
							neg = acc[31] ^ word[31];
							num = acc[31] ? -acc : acc;
							den = word[31] ? -word : word;
							quo = num / den;
							acc = neg ? -quo : quo;
						end
					end
					OP_HALT: halted = 1'b1;
					default: r.status = ST_BAD_OP;
				endcase
			end
			r.accumulator = acc;
			return r;
		endfunction

		function void note_instr(logic [6:0] op, logic [6:0] addr, logic [31:0] value);
			pending_results.push_back(execute_instr(op, addr, value));
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(instr_result_t got);
			instr_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing expected, accumulator %0d",
					$signed(got.accumulator)));
			end else begin
				want = pending_results.pop_front();
				if (got.accumulator !== want.accumulator)
					report($sformatf("accumulator got %0d expected %0d",
						$signed(got.accumulator), $signed(want.accumulator)));
				if (got.write_data !== want.write_data)
					report($sformatf("write_data got %0d expected %0d",
						$signed(got.write_data), $signed(want.write_data)));
				if (got.write_valid !== want.write_valid)
					report($sformatf("write_valid got %b expected %b",
						got.write_valid, want.write_valid));
				if (got.status !== want.status)
					report($sformatf("status got %0d expected %0d",
						got.status, want.status));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   send_pcts [3] = '{9, 66, 0};
	int   recv_pcts [3] = '{66, 9, 0};

	instr_scoreboard sb = new();

	amx_in_if  in_ch ();
	amx_out_if out_ch ();

	accumulator_machine_execute_top #(
		.MEM_WORDS(MEM_WORDS),
		.WORD_BITS(WORD_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		instr_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.accumulator = out_ch.accumulator;
			got.write_data = out_ch.write_data;
			got.write_valid = out_ch.write_valid;
			got.status = status_t'(out_ch.status);
			sb.check_result(got);
		end
	end

	task send_instr(logic [6:0] op, logic [6:0] addr, logic [31:0] value);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.op = op;
		in_ch.address = addr;
		in_ch.read_value = value;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_instr(op, addr, value);
	endtask

	// Holds the sender off until every outstanding request has returned its result.
	task wait_all_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function logic [31:0] random_value();
		case ($urandom_range(0, 9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '1;
			3: return '0;
			4, 5, 6: return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function void random_instr(output logic [6:0] op, output logic [6:0] addr,
			output logic [31:0] value);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 24)      op = OP_READ;
		else if (pick < 34) op = OP_WRITE;
		else if (pick < 46) op = OP_LOAD;
		else if (pick < 56) op = OP_STORE;
		else if (pick < 66) op = OP_ADD;
		else if (pick < 76) op = OP_SUB;
		else if (pick < 84) op = OP_MUL;
		else if (pick < 95) op = OP_DIV;
		else begin
			do
				op = 7'($urandom_range(0, 127));
			while (op inside {OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB,
				OP_MUL, OP_DIV, OP_HALT});
		end
		// A small working set keeps stored values in use by later arithmetic.
		pick = $urandom_range(0, 99);
		if (pick < 70)      addr = 7'($urandom_range(0, 7));
		else if (pick < 95) addr = 7'($urandom_range(0, MEM_WORDS - 1));
		else                addr = 7'($urandom_range(MEM_WORDS, 127));
		value = random_value();
	endfunction

	initial begin
		logic [6:0]  op;
		logic [6:0]  addr;
		logic [31:0] value;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = '0;
		in_ch.address = '0;
		in_ch.read_value = '0;
		send_idle_pct = send_pcts[0];
		recv_idle_pct = recv_pcts[0];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_instr(OP_READ, 7'd0, WORD_MAX);
		send_instr(OP_READ, 7'd1, WORD_MIN);
		send_instr(OP_READ, 7'd2, '1);
		send_instr(OP_READ, 7'd3, 32'd1);
		send_instr(OP_READ, 7'd99, 32'h1234_5678);
		send_instr(OP_READ, 7'd120, 32'd5);
		send_instr(OP_WRITE, 7'd0, '0);
		send_instr(OP_WRITE, 7'd99, '1);
		send_instr(OP_WRITE, 7'd120, '0);
		send_instr(OP_LOAD, 7'd0, '0);
		send_instr(OP_ADD, 7'd3, '0);
		send_instr(OP_SUB, 7'd3, '0);
		send_instr(OP_MUL, 7'd0, '0);
		send_instr(OP_LOAD, 7'd1, '0);
		send_instr(OP_DIV, 7'd2, '0);
		send_instr(OP_DIV, 7'd50, '0);
		send_instr(OP_DIV, 7'd127, '0);
		send_instr(OP_STORE, 7'd5, '0);
		send_instr(OP_WRITE, 7'd5, '0);
		send_instr(OP_STORE, 7'd127, '0);
		send_instr(OP_LOAD, 7'd127, '0);
		send_instr(OP_READ, 7'd4, -32'sd7);
		send_instr(OP_READ, 7'd6, 32'd2);
		send_instr(OP_LOAD, 7'd4, '0);
		send_instr(OP_DIV, 7'd6, '0);
		send_instr(7'd0, 7'd0, '0);
		send_instr(7'd127, 7'd127, '1);
		wait_all_results();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = send_pcts[phase];
			recv_idle_pct = recv_pcts[phase];
			repeat (PHASE_ITEMS) begin
				random_instr(op, addr, value);
				send_instr(op, addr, value);
			end
			wait_all_results();
		end

		// Halt is permanent, so it comes last, followed by requests that must all be refused.
		send_instr(OP_HALT, 7'd0, '0);
		send_instr(OP_WRITE, 7'd0, '0);
		send_instr(OP_READ, 7'd0, 32'd9);
		send_instr(OP_LOAD, 7'd0, '0);
		send_instr(OP_DIV, 7'd50, '0);
		send_instr(7'd99, 7'd3, '0);
		send_instr(OP_HALT, 7'd1, '0);

		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* accumulator_machine_execute_top.f */
rtl/amx_pkg.sv
rtl/amx_if.sv
rtl/amx_ram.sv
rtl/amx_ctrl.sv
rtl/amx_dp.sv
rtl/accumulator_machine_execute_top.sv
rtl/amx_checker.sv
tb/tb_top.sv
